// ===== hdl/bcet_pkg.sv =====
// Shared types and constants for the bias-corrected EMA trend block.
// Self-contained; used by bcet_div and bias_corrected_ema_trend.
package bcet_pkg;

    // Parameter defaults
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int DECAY_W   = 16;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 34;
    localparam int AVG_W     = 24;
    localparam int AVG_SHIFT = 8;
    localparam int MAG_W     = SUM_W + AVG_SHIFT;
    localparam int CHUNK_W   = 24;
    localparam int MULB_W    = CHUNK_W + 1;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    // Output beat layout: average, sum, count from bit 0 up
    localparam int OUT_FIELDS_W = AVG_W + SUM_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd61440;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY     = 2'd0,
        CFG_INIT_SUM  = 2'd1,
        CFG_INIT_CNT  = 2'd2,
        CFG_INIT_RISE = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SL,
        S_MUL_SH,
        S_SUM_ACC,
        S_SUM_FIN,
        S_CNT_ACC,
        S_CNT_FIN,
        S_MUL_RL,
        S_MUL_RH,
        S_RISE_ACC,
        S_RISE_CMP,
        S_DIV,
        S_OUT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [AVG_W-1:0] average;
    } t_div_rsp;

endpackage

// ===== hdl/bias_corrected_ema_trend.sv =====
// Bias-corrected exponential moving average with trend flag: top level.
// Depends on bcet_pkg and bcet_div.
//
// Usage:
//   Input beats arrive on s_axis_*: tdata carries the signed sample, tuser the restore
//   flag, which reloads the sum, count and flag from the initial registers before
//   the sample is applied. Each input beat yields exactly one output beat on m_axis_*:
//   tdata carries average (Q15.8), weighted sum (Q31.16) and weighted count (Q18.16);
//   tuser carries the rising flag. Registers are written through i_cfg_wr_en /
//   i_cfg_index / i_cfg_data: 0 decay, 1 initial sum, 2 initial count, 3 initial flag.
//   The user must write them only while idle; the block does not enforce this.
// Sequencing:
//   One item at a time. A single 17 x 25 multiplier and adder walk through the
//   decay products and the sample-times-count product, then the radix-2 divider
//   forms the quotient and hands it back, and the result moves to the output
//   register. s_axis_tready is high only between items.
// Reset and stall:
//   Synchronous active-low reset clears the state to zero, the registers to
//   their defaults and drops m_axis_tvalid. A result waits in the output
//   register while m_axis_tready is low; the next item may still be accepted,
//   and its result holds in the sequencer until the output register frees.
module bias_corrected_ema_trend #(
    parameter int SAMPLE_WIDTH  = bcet_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = bcet_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_wr_en,
    input  logic [bcet_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bcet_pkg::CFG_W-1:0]             i_cfg_data,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample
    input  logic                                   s_axis_tuser,  // restore
    // Output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [bcet_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // average, sum, count
    output logic                                   m_axis_tuser   // rising
);
    import bcet_pkg::*;

    localparam int AW     = ((SAMPLE_WIDTH > DECAY_W) ? SAMPLE_WIDTH : DECAY_W) + 1;
    localparam int PROD_W = AW + MULB_W;
    localparam int ACC_W  = ((SAMPLE_WIDTH + CNT_W + 1) > (DECAY_W + SUM_W + 2)) ?
                            (SAMPLE_WIDTH + CNT_W + 1) : (DECAY_W + SUM_W + 2);
    localparam logic [CNT_W:0] CNT_ONE = (CNT_W+1)'(1) << FRACTION_BITS;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    t_state r_state, n_state;

    // Configuration registers
    logic [DECAY_W-1:0]        r_decay;
    logic signed [SUM_W-1:0]   r_init_sum;
    logic [CNT_W-1:0]          r_init_cnt;
    logic                      r_init_rise;

    // Filter state
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_rising;

    // Datapath
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [AVG_W-1:0]   r_avg;

    // Output register
    logic                      r_m_valid;
    logic signed [AVG_W-1:0]   r_o_avg;
    logic signed [SUM_W-1:0]   r_o_sum;
    logic [CNT_W-1:0]          r_o_cnt;
    logic                      r_o_rising;

    logic                      in_fire;
    logic                      out_load;
    logic signed [AW-1:0]      mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_add;
    logic signed [ACC_W-1:0]   sample_ext;
    logic signed [ACC_W-1:0]   sum_ext;
    logic signed [ACC_W-1:0]   ns_wide;
    logic signed [SUM_W-1:0]   ns_sat;
    logic [CNT_W:0]            nc_wide;
    logic [CNT_W-1:0]          nc_sat;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = S_MUL_SL;
            end
            S_MUL_SL:   n_state = S_MUL_SH;
            S_MUL_SH:   n_state = S_SUM_ACC;
            S_SUM_ACC:  n_state = S_SUM_FIN;
            S_SUM_FIN:  n_state = S_CNT_ACC;
            S_CNT_ACC:  n_state = S_CNT_FIN;
            S_CNT_FIN:  n_state = S_MUL_RL;
            S_MUL_RL:   n_state = S_MUL_RH;
            S_MUL_RH:   n_state = S_RISE_ACC;
            S_RISE_ACC: n_state = S_RISE_CMP;
            S_RISE_CMP: n_state = S_DIV;
            S_DIV: begin
                if (div_rsp.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Shared multiplier operand select: decay or sample times a chunk of up to 24 bits
    always_comb begin
        mul_a = $signed({{(AW-DECAY_W){1'b0}}, r_decay});
        mul_b = $signed({1'b0, r_sum[CHUNK_W-1:0]});
        case (r_state)
            S_MUL_SH:  mul_b = $signed({r_sum[SUM_W-1], r_sum[SUM_W-1:CHUNK_W]});
            S_SUM_ACC: mul_b = $signed({1'b0, r_cnt[CHUNK_W-1:0]});
            S_SUM_FIN: mul_b = $signed({{(MULB_W-(CNT_W-CHUNK_W)){1'b0}},
                                        r_cnt[CNT_W-1:CHUNK_W]});
            S_MUL_RL: begin
                mul_a = $signed({{(AW-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample});
                mul_b = $signed({1'b0, r_cnt[CHUNK_W-1:0]});
            end
            S_MUL_RH: begin
                mul_a = $signed({{(AW-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample});
                mul_b = $signed({{(MULB_W-(CNT_W-CHUNK_W)){1'b0}},
                                 r_cnt[CNT_W-1:CHUNK_W]});
            end
            default: ;
        endcase
    end

    // Accumulate a high-chunk product onto the low-chunk one
    assign prod_ext = $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
    assign acc_add  = r_acc + (prod_ext <<< CHUNK_W);

    // New sum: sample scaled to the fraction, plus the floored decay product, saturated
    assign sample_ext = $signed({{(ACC_W-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample});
    assign ns_wide    = (sample_ext <<< FRACTION_BITS) + (r_acc >>> DECAY_W);
    always_comb begin
        if (&ns_wide[ACC_W-1:SUM_W-1] || ~|ns_wide[ACC_W-1:SUM_W-1]) begin
            ns_sat = ns_wide[SUM_W-1:0];
        end else begin
            ns_sat = ns_wide[ACC_W-1] ? SUM_MIN : SUM_MAX;
        end
    end

    // New count: one plus the truncated decay product, saturated
    assign nc_wide = {1'b0, r_acc[CNT_W+DECAY_W-1:DECAY_W]} + CNT_ONE;
    assign nc_sat  = nc_wide[CNT_W] ? {CNT_W{1'b1}} : nc_wide[CNT_W-1:0];

    assign sum_ext = $signed({{(ACC_W-SUM_W){r_sum[SUM_W-1]}}, r_sum});

    // Configuration writes and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= DECAY_RESET;
            r_init_sum  <= '0;
            r_init_cnt  <= '0;
            r_init_rise <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_rising    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DECAY:     r_decay     <= i_cfg_data[DECAY_W-1:0];
                    CFG_INIT_SUM:  r_init_sum  <= i_cfg_data[SUM_W-1:0];
                    CFG_INIT_CNT:  r_init_cnt  <= i_cfg_data[CNT_W-1:0];
                    CFG_INIT_RISE: r_init_rise <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_fire && s_axis_tuser) begin
                r_sum    <= r_init_sum;
                r_cnt    <= r_init_cnt;
                r_rising <= r_init_rise;
            end
            if (r_state == S_SUM_FIN) r_sum <= ns_sat;
            if (r_state == S_CNT_FIN) r_cnt <= nc_sat;
            if (r_state == S_RISE_CMP) r_rising <= (r_acc > sum_ext);
        end
    end

    // Multiplier, accumulator and sample capture
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) r_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        case (r_state)
            S_MUL_SH, S_SUM_FIN, S_MUL_RH:   r_acc <= prod_ext;
            S_SUM_ACC, S_CNT_ACC, S_RISE_ACC: r_acc <= acc_add;
            default: ;
        endcase
        if (r_state == S_DIV && div_rsp.done) r_avg <= div_rsp.average;
    end

    // Divider
    assign div_req.start = (r_state == S_RISE_CMP);
    assign div_req.sum   = r_sum;
    assign div_req.count = r_cnt;

    bcet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output register: load when free, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_avg    <= r_avg;
            r_o_sum    <= r_sum;
            r_o_cnt    <= r_cnt;
            r_o_rising <= r_rising;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, r_o_cnt, r_o_sum, r_o_avg};
    assign m_axis_tuser  = r_o_rising;

endmodule

// ===== hdl/bcet_div.sv =====
// Radix-2 restoring divider: saturated signed Q15.8 average of sum*256 / count.
// Depends on bcet_pkg.
module bcet_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcet_pkg::t_div_req i_req,
    output bcet_pkg::t_div_rsp o_rsp
);
    import bcet_pkg::*;

    localparam int HI_W = MAG_W - AVG_W;
    localparam int CW   = $clog2(AVG_W + 1);
    localparam logic [CW-1:0] STEPS = CW'(AVG_W);
    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

    logic [SUM_W-1:0]  sum_bits;
    logic [SUM_W-1:0]  sum_abs;
    logic [MAG_W-1:0]  mag;
    logic [HI_W-1:0]   mag_hi;
    logic              ovf_start;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [AVG_W-1:0]  avg;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_steps;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [AVG_W-1:0]  r_num;
    logic [AVG_W-1:0]  r_q;
    logic              r_neg;
    logic              r_ovf;
    logic              r_zero;

    // Magnitude of the numerator; its top 32 bits must stay below the divisor, else overflow
    assign sum_bits  = i_req.sum;
    assign sum_abs   = sum_bits[SUM_W-1] ? (~sum_bits + {{(SUM_W-1){1'b0}}, 1'b1}) : sum_bits;
    assign mag       = {sum_abs, {AVG_SHIFT{1'b0}}};
    assign mag_hi    = mag[MAG_W-1:AVG_W];
    assign ovf_start = {{(CNT_W-HI_W){1'b0}}, mag_hi} >= i_req.count;

    // One quotient bit per cycle
    assign trial = {r_rem, r_num[AVG_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= STEPS;
            end else if (r_busy) begin
                r_steps <= r_steps - CW'(1);
                if (r_steps == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {{(CNT_W-HI_W){1'b0}}, mag_hi};
            r_num  <= mag[AVG_W-1:0];
            r_div  <= i_req.count;
            r_q    <= '0;
            r_neg  <= sum_bits[SUM_W-1];
            r_ovf  <= ovf_start;
            r_zero <= (i_req.count == '0);
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_num <= {r_num[AVG_W-2:0], 1'b0};
            r_q   <= {r_q[AVG_W-2:0], ge};
        end
    end

    // Apply sign and saturate
    always_comb begin
        if (r_zero) begin
            avg = '0;
        end else if (!r_neg) begin
            avg = (r_ovf || r_q[AVG_W-1]) ? AVG_MAX : r_q;
        end else if (r_ovf || (r_q[AVG_W-1] && |r_q[AVG_W-2:0])) begin
            avg = AVG_MIN;
        end else begin
            avg = ~r_q + {{(AVG_W-1){1'b0}}, 1'b1};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.average = avg;

endmodule

// ===== verif/bias_corrected_ema_trend_test.sv =====
// Self-checking testbench for bias_corrected_ema_trend: a directed table, then random
// phases under several register settings, most with random idling on both streams.
// Depends on bcet_pkg and the RTL of bias_corrected_ema_trend.
module bias_corrected_ema_trend_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcet_pkg::*;

    localparam int     PHASES          = 8;
    localparam int     ITEMS_PER_PHASE = 250;
    localparam int     SETTLE_CYCLES   = 45;
    localparam int     LIMIT_CYCLES    = 2_000_000;
    localparam longint FRAC_ONE        = 64'sd65536;
    localparam longint SUM_TOP         = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_BOTTOM      = -SUM_TOP - 64'sd1;
    localparam longint COUNT_TOP       = 64'sh0000_0003_FFFF_FFFF;
    localparam longint AVG_TOP         = 64'sd8388607;
    localparam longint AVG_BOTTOM      = -64'sd8388608;

    // One output beat, split into its fields
    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    rising;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } t_ema_result;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // One line of the directed table
    typedef struct {
        t_row_kind          kind;
        t_cfg_idx           idx;
        logic [CFG_W-1:0]   data;
        logic signed [15:0] point;
        bit                 restore;
        bit                 typed;
        t_ema_result        want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // sample
    logic                  s_axis_tuser = 1'b0; // restore
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // average, weighted sum, weighted count
    logic                  m_axis_tuser;        // rising

    // Predictor copy of the registers and the running state
    logic [15:0]             cfg_decay = DECAY_RESET;
    logic signed [SUM_W-1:0] cfg_init_sum = '0;
    logic [CNT_W-1:0]        cfg_init_count = '0;
    logic                    cfg_init_rise = 1'b0;
    longint                  ema_sum = 0;
    longint                  ema_count = 0;
    bit                      ema_rise = 1'b0;

    t_ema_result pending_results[$];
    t_row        stim_table[$];
    bit          idle_on = 1'b0;
    int          rx_hold = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          beats_checked = 0;
    int          directed_items = 0;
    int          random_items = 0;
    int          restore_count = 0;
    int          setting_count = 0;

    bias_corrected_ema_trend uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Advance the EMA by one sample and return the beat it should produce
    function automatic t_ema_result ema_update(input logic signed [15:0] point,
                                               input bit restore);
        longint      s;
        longint      ns;
        longint      nc;
        longint      quo;
        t_ema_result r;
        if (restore) begin
            ema_sum   = cfg_init_sum;
            ema_count = cfg_init_count;
            ema_rise  = cfg_init_rise;
        end
        s  = point;
        // products floor toward minus infinity, then saturate
        ns = s * FRAC_ONE + ((longint'(cfg_decay) * ema_sum) >>> 16);
        if (ns > SUM_TOP) ns = SUM_TOP;
        if (ns < SUM_BOTTOM) ns = SUM_BOTTOM;
        nc = FRAC_ONE + ((longint'(cfg_decay) * ema_count) >>> 16);
        if (nc > COUNT_TOP) nc = COUNT_TOP;
        ema_sum   = ns;
        ema_count = nc;
        ema_rise  = (s * nc > ns);
        // Q15.8 quotient, truncated toward zero
        quo = (nc == 0) ? 64'sd0 : (ns * 256) / nc;
        if (quo > AVG_TOP) quo = AVG_TOP;
        if (quo < AVG_BOTTOM) quo = AVG_BOTTOM;
        r.average = quo[AVG_W-1:0];
        r.rising  = ema_rise;
        r.sum     = ns[SUM_W-1:0];
        r.count   = nc[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_ema_result make_result(input longint avg, input bit rise,
                                                input longint sum, input longint cnt);
        t_ema_result r;
        r.average = avg[AVG_W-1:0];
        r.rising  = rise;
        r.sum     = sum[SUM_W-1:0];
        r.count   = cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_row cfg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        t_row r;
        r = '{kind: ROW_CFG, idx: idx, data: data, point: '0, restore: 1'b0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_row item_row(input logic signed [15:0] point, input bit restore);
        t_row r;
        r = '{kind: ROW_ITEM, idx: CFG_DECAY, data: '0, point: point, restore: restore,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_row typed_row(input logic signed [15:0] point, input bit restore,
                                       input t_ema_result want);
        t_row r;
        r = item_row(point, restore);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none in quiet phases
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [15:0] pick_point();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sd0;
                3: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        if (r <= 3) return 16'($urandom_range(0, 200) - 100);
        return 16'($urandom);
    endfunction

    // Present one beat, hold until taken, then maybe drop valid for a gap
    task automatic send_item(input logic signed [15:0] point, input bit restore);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= point;
        s_axis_tuser  <= restore;
        do @(posedge i_clk); while (!s_axis_tready);
        if (restore) restore_count++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected beat is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DECAY:     cfg_decay      = data[15:0];
            CFG_INIT_SUM:  cfg_init_sum   = data[SUM_W-1:0];
            CFG_INIT_CNT:  cfg_init_count = data[CNT_W-1:0];
            CFG_INIT_RISE: cfg_init_rise  = data[0];
            default: ;
        endcase
        setting_count++;
    endtask

    // Check each output beat against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin : rx_check
        t_ema_result exp_beat;
        t_ema_result got_beat;
        got_beat.average = m_axis_tdata[AVG_W-1:0];
        got_beat.sum     = m_axis_tdata[AVG_W +: SUM_W];
        got_beat.count   = m_axis_tdata[AVG_W+SUM_W +: CNT_W];
        got_beat.rising  = m_axis_tuser;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, expected none, got average %0d sum %0d",
                         $time, got_beat.average, got_beat.sum);
            end else begin
                exp_beat = pending_results.pop_front();
                if (got_beat.average !== exp_beat.average) begin
                    error_count++;
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, exp_beat.average, got_beat.average);
                end
                if (got_beat.rising !== exp_beat.rising) begin
                    error_count++;
                    $display("%0t: rising mismatch, expected %0b, got %0b",
                             $time, exp_beat.rising, got_beat.rising);
                end
                if (got_beat.sum !== exp_beat.sum) begin
                    error_count++;
                    $display("%0t: weighted sum mismatch, expected %0d, got %0d",
                             $time, exp_beat.sum, got_beat.sum);
                end
                if (got_beat.count !== exp_beat.count) begin
                    error_count++;
                    $display("%0t: weighted count mismatch, expected %0d, got %0d",
                             $time, exp_beat.count, got_beat.count);
                end
            end
        end
        // back-pressure: short stalls, now and then a long one
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 65) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d beats outstanding",
                     $time, cycle_count, pending_results.size());
            $display("bias_corrected_ema_trend_test: errors");
            $finish;
        end
    end

    initial begin
        t_row        row;
        t_ema_result pred;
        int          phase;
        int          n;
        int          r;
        logic [CFG_W-1:0] word;

        // Directed table: reset state, decay extremes, saturation, restore
        stim_table.push_back(typed_row(16'sd0, 1'b0, make_result(0, 1'b0, 0, 65536)));
        stim_table.push_back(cfg_row(CFG_DECAY, 48'd0));
        stim_table.push_back(typed_row(16'sh7FFF, 1'b0,
                                       make_result(8388352, 1'b0, 2147418112, 65536)));
        stim_table.push_back(typed_row(16'sh8000, 1'b0,
                                       make_result(-8388608, 1'b0, -64'sd2147483648, 65536)));
        stim_table.push_back(typed_row(16'sd0, 1'b0, make_result(0, 1'b0, 0, 65536)));
        stim_table.push_back(cfg_row(CFG_DECAY, 48'd65535));
        stim_table.push_back(item_row(16'sd1, 1'b0));
        stim_table.push_back(item_row(16'sd1, 1'b0));
        stim_table.push_back(item_row(-16'sd1, 1'b0));
        stim_table.push_back(item_row(16'sd100, 1'b0));
        stim_table.push_back(cfg_row(CFG_INIT_SUM, 48'h7FFF_FFFF_FFFF));
        stim_table.push_back(cfg_row(CFG_INIT_CNT, 48'd0));
        stim_table.push_back(cfg_row(CFG_INIT_RISE, 48'd1));
        stim_table.push_back(item_row(16'sh7FFF, 1'b1));
        stim_table.push_back(item_row(16'sh8000, 1'b0));
        stim_table.push_back(cfg_row(CFG_INIT_SUM, 48'h8000_0000_0000));
        stim_table.push_back(cfg_row(CFG_INIT_CNT, 48'h3_FFFF_FFFF));
        stim_table.push_back(cfg_row(CFG_INIT_RISE, 48'd0));
        stim_table.push_back(item_row(16'sh8000, 1'b1));
        stim_table.push_back(item_row(16'sh7FFF, 1'b1));
        stim_table.push_back(item_row(16'sh7FFF, 1'b0));
        // restored flag is recomputed, never passed through
        stim_table.push_back(cfg_row(CFG_INIT_SUM, 48'd0));
        stim_table.push_back(cfg_row(CFG_INIT_CNT, 48'd0));
        stim_table.push_back(cfg_row(CFG_INIT_RISE, 48'd1));
        stim_table.push_back(cfg_row(CFG_DECAY, 48'd0));
        stim_table.push_back(typed_row(16'sd0, 1'b1, make_result(0, 1'b0, 0, 65536)));
        stim_table.push_back(cfg_row(CFG_DECAY, 48'd61440));
        stim_table.push_back(item_row(16'sd5, 1'b0));
        stim_table.push_back(item_row(16'sd5, 1'b0));
        stim_table.push_back(item_row(-16'sd7, 1'b0));

        // Hold reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.idx, row.data);
            end else begin
                pred = ema_update(row.point, row.restore);
                pending_results.push_back(row.typed ? row.want : pred);
                directed_items++;
                send_item(row.point, row.restore);
            end
        end

        // Random phases, each under a fresh register setting
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            idle_on = (phase % 4) != 0;
            case (phase)
                0: word = 48'd0;
                1: word = 48'd65535;
                2: word = 48'd61440;
                default: begin
                    r = $urandom_range(0, 2);
                    if (r == 0) word = CFG_W'($urandom_range(0, 65535));
                    else if (r == 1) word = CFG_W'(65535 - $urandom_range(0, 255));
                    else word = CFG_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_DECAY, word);
            r = $urandom_range(0, 3);
            if (r == 0) word = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            else if (r == 1) word = CFG_W'({$urandom, $urandom});
            else begin
                word[31:0]  = $urandom;
                word[47:32] = {16{word[31]}};
            end
            write_reg(CFG_INIT_SUM, word);
            r = $urandom_range(0, 3);
            if (r == 0) word = CFG_W'({$urandom, $urandom} | 64'h3_FFFF_FFFF);
            else if (r == 1) word = CFG_W'({$urandom, $urandom});
            else word = CFG_W'($urandom_range(0, 1 << 20));
            write_reg(CFG_INIT_CNT, word);
            write_reg(CFG_INIT_RISE, CFG_W'({$urandom, $urandom}));

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // let the pipeline run dry once mid-stream
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) drain_results();
                row = item_row(pick_point(), $urandom_range(0, 15) == 0);
                pending_results.push_back(ema_update(row.point, row.restore));
                random_items++;
                send_item(row.point, row.restore);
            end
        end

        drain_results();

        $display("covered %0d directed and %0d random beats, %0d restores, %0d register writes",
                 directed_items, random_items, restore_count, setting_count);
        $display("checked %0d output beats, %0d field mismatches", beats_checked, error_count);
        if (error_count == 0) begin
            $display("bias_corrected_ema_trend_test: clean");
        end else begin
            $display("bias_corrected_ema_trend_test: errors");
        end
        $finish;
    end

endmodule
